/* hdl/tgr_pkg.sv */
// ----------------------------------------------------------------------------
// tgr_pkg: shared types, constants and font table of the text glyph generator
// Holds the item classification codes, the queue entry layout, the register
// file image and the fixed 5x7 uppercase font.
// ----------------------------------------------------------------------------
package tgr_pkg;

   localparam int COORD_BITS     = 16;
   localparam int CODE_BITS      = 8;
   localparam int SCALE_BITS     = 4;
   localparam int COLOR_BITS     = 32;
   localparam int GLYPH_W        = 5;
   localparam int GLYPH_H        = 7;
   localparam int GLYPH_COUNT    = 26;
   localparam int LETTER_BITS    = 5;
   localparam int ROW_BITS       = 3;
   localparam int COL_BITS       = 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_IDX_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [CODE_BITS-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CODE_BITS-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CODE_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CODE_BITS-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CODE_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CODE_BITS-1:0] CHAR_UPPER_Z = 8'h5A;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [SCALE_BITS-1:0] scale_type;
   typedef logic [COLOR_BITS-1:0] color_type;
   typedef logic [LETTER_BITS-1:0] letter_type;
   typedef logic [GLYPH_W-1:0] glyph_row_type;

   // register indexes on the configuration port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ORIGIN_X    = 2'd0,
      CSR_ORIGIN_Y    = 2'd1,
      CSR_PIXEL_SCALE = 2'd2,
      CSR_INK_COLOR   = 2'd3
   } csr_idx_type;

   // what the back end must do with one character
   typedef enum logic [1:0] {
      KIND_NUL     = 2'd0,
      KIND_NEWLINE = 2'd1,
      KIND_ADVANCE = 2'd2,
      KIND_GLYPH   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      letter_type letter;
      logic       new_text;
   } entry_type;

   typedef struct packed {
      coord_type origin_x;
      coord_type origin_y;
      scale_type pixel_scale;
      color_type ink_color;
   } cfg_type;

   // bit GLYPH_W-1 of a row is the leftmost dot
   localparam glyph_row_type GLYPH_ROM [0:GLYPH_COUNT-1][0:GLYPH_H-1] = '{
      '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
      '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
      '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
      '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
      '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
      '{5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E},
      '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
      '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
      '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
      '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
      '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
      '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
      '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
      '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}
   };

   // six scaled columns: one glyph plus one blank column
   function automatic coord_type advance_x(input scale_type s);
      logic [SCALE_BITS+2:0] prod;
      prod = {1'b0, s, 2'b00} + {2'b00, s, 1'b0};
      return COORD_BITS'(prod);
   endfunction

   // nine scaled rows: one glyph plus two blank rows
   function automatic coord_type advance_y(input scale_type s);
      logic [SCALE_BITS+3:0] prod;
      prod = {1'b0, s, 3'b000} + {4'b0000, s};
      return COORD_BITS'(prod);
   endfunction

endpackage

/* hdl/tgr_front.sv */
// ----------------------------------------------------------------------------
// tgr_front: character classifier
// Takes request beats, sorts each character into nul, newline, advance-only
// or glyph, folds letters to a font index and pushes the result to the queue.
// ----------------------------------------------------------------------------
module tgr_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tgr_pkg::CODE_BITS-1:0]     req_char_code,
   input  logic                              req_new_text,
   input  logic                              queue_full,
   output logic                              push,
   output tgr_pkg::entry_type                push_entry
);

   logic [tgr_pkg::CODE_BITS-1:0] lower_off;
   logic [tgr_pkg::CODE_BITS-1:0] upper_off;
   logic                          is_lower;
   logic                          is_upper;
   logic                          seen_ff;
   logic                          seen_in;

   assign lower_off = req_char_code - tgr_pkg::CHAR_LOWER_A;
   assign upper_off = req_char_code - tgr_pkg::CHAR_UPPER_A;
   assign is_lower  = (req_char_code >= tgr_pkg::CHAR_LOWER_A) &&
                      (req_char_code <= tgr_pkg::CHAR_LOWER_Z);
   assign is_upper  = (req_char_code >= tgr_pkg::CHAR_UPPER_A) &&
                      (req_char_code <= tgr_pkg::CHAR_UPPER_Z);

   assign req_ready = !queue_full && seen_ff;
   assign push      = req_valid && req_ready;

   always_comb begin
      push_entry.new_text = req_new_text;
      push_entry.letter   = '0;
      if (req_char_code == tgr_pkg::CHAR_NUL) begin
         push_entry.kind = tgr_pkg::KIND_NUL;
      end else if (req_char_code == tgr_pkg::CHAR_NEWLINE) begin
         push_entry.kind = tgr_pkg::KIND_NEWLINE;
      end else if (is_lower) begin
         push_entry.kind   = tgr_pkg::KIND_GLYPH;
         push_entry.letter = lower_off[tgr_pkg::LETTER_BITS-1:0];
      end else if (is_upper) begin
         push_entry.kind   = tgr_pkg::KIND_GLYPH;
         push_entry.letter = upper_off[tgr_pkg::LETTER_BITS-1:0];
      end else begin
         push_entry.kind = tgr_pkg::KIND_ADVANCE;
      end
   end

   // hold off the first beat until the cycle after reset is released
   assign seen_in = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

/* hdl/tgr_queue.sv */
// ----------------------------------------------------------------------------
// tgr_queue: two-entry command queue
// Decouples the classifier from the rectangle scanner.
// ----------------------------------------------------------------------------
module tgr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tgr_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output tgr_pkg::entry_type head_entry
);

   tgr_pkg::entry_type                  store_ff [tgr_pkg::QUEUE_DEPTH];
   logic [tgr_pkg::QUEUE_IDX_BITS-1:0]  wr_ptr_ff;
   logic [tgr_pkg::QUEUE_IDX_BITS-1:0]  wr_ptr_in;
   logic [tgr_pkg::QUEUE_IDX_BITS-1:0]  rd_ptr_ff;
   logic [tgr_pkg::QUEUE_IDX_BITS-1:0]  rd_ptr_in;
   logic [tgr_pkg::QUEUE_CNT_BITS-1:0]  count_ff;
   logic [tgr_pkg::QUEUE_CNT_BITS-1:0]  count_in;
   logic                                do_push;
   logic                                do_pop;

   function automatic logic [tgr_pkg::QUEUE_IDX_BITS-1:0] QUEUE_ONE(input logic en);
      return {{(tgr_pkg::QUEUE_IDX_BITS-1){1'b0}}, en};
   endfunction

   assign full       = (count_ff == tgr_pkg::QUEUE_CNT_BITS'(tgr_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_ONE(do_push);
      rd_ptr_in = rd_ptr_ff + QUEUE_ONE(do_pop);
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hdl/tgr_back.sv */
// ----------------------------------------------------------------------------
// tgr_back: pen keeper and dot scanner
// Pops one command at a time, updates the pen, walks the set dots of a glyph
// one per cycle while the response is free and drives the response register.
// ----------------------------------------------------------------------------
module tgr_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tgr_pkg::cfg_type                     cfg,
   input  logic                                 head_valid,
   input  tgr_pkg::entry_type                   head_entry,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tgr_pkg::COORD_BITS-1:0]       rsp_rect_x,
   output logic [tgr_pkg::COORD_BITS-1:0]       rsp_rect_y,
   output logic [tgr_pkg::SCALE_BITS-1:0]       rsp_rect_size,
   output logic [tgr_pkg::COLOR_BITS-1:0]       rsp_rect_color,
   output logic                                 rsp_last_of_char
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   localparam logic [tgr_pkg::ROW_BITS-1:0] LAST_ROW = tgr_pkg::ROW_BITS'(tgr_pkg::GLYPH_H - 1);

   state_type                        state_ff;
   tgr_pkg::coord_type               pen_x_ff;
   tgr_pkg::coord_type               pen_y_ff;
   tgr_pkg::coord_type               glyph_x_ff;
   tgr_pkg::coord_type               glyph_y_ff;
   tgr_pkg::letter_type              letter_ff;
   logic [tgr_pkg::ROW_BITS-1:0]     row_ff;
   tgr_pkg::glyph_row_type           mask_ff;
   logic                             rsp_valid_ff;
   tgr_pkg::coord_type               rect_x_ff;
   tgr_pkg::coord_type               rect_y_ff;
   tgr_pkg::scale_type               rect_size_ff;
   tgr_pkg::color_type               rect_color_ff;
   logic                             last_ff;

   tgr_pkg::coord_type               base_x;
   tgr_pkg::coord_type               base_y;
   logic [tgr_pkg::ROW_BITS-1:0]     row_next;
   tgr_pkg::glyph_row_type           mask_clr;
   logic [tgr_pkg::COL_BITS-1:0]     col;
   logic                             out_free;
   logic                             emit;
   logic                             row_done;
   logic [tgr_pkg::COL_BITS+tgr_pkg::SCALE_BITS-1:0] col_off;
   logic [tgr_pkg::ROW_BITS+tgr_pkg::SCALE_BITS-1:0] row_off;

   assign pop      = (state_ff == ST_IDLE) && head_valid;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (state_ff == ST_SCAN) && (mask_ff != '0) && out_free;
   assign row_next = row_ff + 1'b1;

   assign base_x = head_entry.new_text ? cfg.origin_x : pen_x_ff;
   assign base_y = head_entry.new_text ? cfg.origin_y : pen_y_ff;

   // leftmost remaining dot of the row
   always_comb begin
      col = '0;
      for (int i = tgr_pkg::GLYPH_W - 1; i >= 0; i--) begin
         if (mask_ff[tgr_pkg::GLYPH_W-1-i]) begin
            col = tgr_pkg::COL_BITS'(i);
         end
      end
   end

   assign mask_clr = mask_ff & ~(tgr_pkg::glyph_row_type'(1 << (tgr_pkg::GLYPH_W - 1)) >> col);
   assign row_done = (mask_clr == '0);
   assign col_off  = col * cfg.pixel_scale;
   assign row_off  = row_ff * cfg.pixel_scale;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load the response register on a new dot, else drop it once taken
         if (emit) begin
            rsp_valid_ff  <= 1'b1;
            rect_x_ff     <= glyph_x_ff + tgr_pkg::COORD_BITS'(col_off);
            rect_y_ff     <= glyph_y_ff + tgr_pkg::COORD_BITS'(row_off);
            rect_size_ff  <= cfg.pixel_scale;
            rect_color_ff <= cfg.ink_color;
            last_ff       <= row_done && (row_ff == LAST_ROW);
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  glyph_x_ff <= base_x;
                  glyph_y_ff <= base_y;
                  letter_ff  <= head_entry.letter;
                  row_ff     <= '0;
                  mask_ff    <= tgr_pkg::GLYPH_ROM[head_entry.letter][0];
                  case (head_entry.kind)
                     tgr_pkg::KIND_NEWLINE: begin
                        pen_x_ff <= cfg.origin_x;
                        pen_y_ff <= base_y + tgr_pkg::advance_y(cfg.pixel_scale);
                     end
                     tgr_pkg::KIND_ADVANCE: begin
                        pen_x_ff <= base_x + tgr_pkg::advance_x(cfg.pixel_scale);
                        pen_y_ff <= base_y;
                     end
                     tgr_pkg::KIND_GLYPH: begin
                        pen_x_ff <= base_x + tgr_pkg::advance_x(cfg.pixel_scale);
                        pen_y_ff <= base_y;
                        if (cfg.pixel_scale != '0) begin
                           state_ff <= ST_SCAN;
                        end
                     end
                     default: begin
                        pen_x_ff <= base_x;
                        pen_y_ff <= base_y;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               // every row of the font holds a dot, so the last row ends the run
               if (mask_ff == '0) begin
                  if (row_ff == LAST_ROW) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     row_ff  <= row_next;
                     mask_ff <= tgr_pkg::GLYPH_ROM[letter_ff][row_next];
                  end
               end else if (emit) begin
                  if (row_done && (row_ff != LAST_ROW)) begin
                     row_ff  <= row_next;
                     mask_ff <= tgr_pkg::GLYPH_ROM[letter_ff][row_next];
                  end else begin
                     mask_ff <= mask_clr;
                  end
                  if (row_done && (row_ff == LAST_ROW)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rect_x       = rect_x_ff;
   assign rsp_rect_y       = rect_y_ff;
   assign rsp_rect_size    = rect_size_ff;
   assign rsp_rect_color   = rect_color_ff;
   assign rsp_last_of_char = last_ff;

endmodule

/* hdl/text_glyph_rectangle_generator.sv */
// ----------------------------------------------------------------------------
// text_glyph_rectangle_generator: 5x7 bitmap font character generator
// Turns a stream of character bytes into filled squares, one per font dot,
// while keeping a pen position for the text.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  req       in         req_valid/req_ready  req_char_code, req_new_text
//  rsp       out        rsp_valid/rsp_ready  rsp_rect_x/_y/_size/_color, last_of_char
//  csr       in         psel/penable/pready  paddr, pwrite, pwdata, prdata
//
//  A letter leaves the queue, then the back end scanner emits its set dots
//  (up to 20 for this font) one beat per cycle unless the response stalls;
//  any other byte is done once it leaves the queue. Reset is synchronous and
//  empties the queue, clears the pen and loads the register reset values;
//  the request side opens in the cycle after reset is released. A stalled
//  response holds its register and stops the scanner, while the front keeps
//  taking beats until the two-entry queue fills.
//
module text_glyph_rectangle_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tgr_pkg::CODE_BITS-1:0]        req_char_code,
   input  logic                                 req_new_text,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tgr_pkg::COORD_BITS-1:0]       rsp_rect_x,
   output logic [tgr_pkg::COORD_BITS-1:0]       rsp_rect_y,
   output logic [tgr_pkg::SCALE_BITS-1:0]       rsp_rect_size,
   output logic [tgr_pkg::COLOR_BITS-1:0]       rsp_rect_color,
   output logic                                 rsp_last_of_char,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tgr_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [tgr_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [tgr_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready
);

   tgr_pkg::cfg_type     cfg_ff;
   tgr_pkg::cfg_type     cfg_in;
   tgr_pkg::csr_idx_type csr_idx;
   logic                 csr_write;

   logic                 push;
   tgr_pkg::entry_type   push_entry;
   logic                 queue_full;
   logic                 pop;
   logic                 head_valid;
   tgr_pkg::entry_type   head_entry;

   // register file: the word index sits above the byte offset
   assign pready    = 1'b1;
   assign csr_idx   = tgr_pkg::csr_idx_type'(paddr[tgr_pkg::CSR_ADDR_BITS-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_idx)
            tgr_pkg::CSR_ORIGIN_X:    cfg_in.origin_x    = pwdata[tgr_pkg::COORD_BITS-1:0];
            tgr_pkg::CSR_ORIGIN_Y:    cfg_in.origin_y    = pwdata[tgr_pkg::COORD_BITS-1:0];
            tgr_pkg::CSR_PIXEL_SCALE: cfg_in.pixel_scale = pwdata[tgr_pkg::SCALE_BITS-1:0];
            tgr_pkg::CSR_INK_COLOR:   cfg_in.ink_color   = pwdata[tgr_pkg::COLOR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // read back the addressed register, zero-extended
   always_comb begin
      unique case (csr_idx)
         tgr_pkg::CSR_ORIGIN_X:    prdata = tgr_pkg::CSR_DATA_BITS'(cfg_ff.origin_x);
         tgr_pkg::CSR_ORIGIN_Y:    prdata = tgr_pkg::CSR_DATA_BITS'(cfg_ff.origin_y);
         tgr_pkg::CSR_PIXEL_SCALE: prdata = tgr_pkg::CSR_DATA_BITS'(cfg_ff.pixel_scale);
         tgr_pkg::CSR_INK_COLOR:   prdata = tgr_pkg::CSR_DATA_BITS'(cfg_ff.ink_color);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.pixel_scale <= tgr_pkg::SCALE_BITS'(1);
         cfg_ff.ink_color   <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify each request beat and push it to the queue
   tgr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_new_text  (req_new_text),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   // queue: let the front keep accepting while the scanner stalls
   tgr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // back: move the pen and scan glyph dots into response beats
   tgr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rect_x       (rsp_rect_x),
      .rsp_rect_y       (rsp_rect_y),
      .rsp_rect_size    (rsp_rect_size),
      .rsp_rect_color   (rsp_rect_color),
      .rsp_last_of_char (rsp_last_of_char)
   );

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: text glyph rectangle generator testbench
// Sends character beats, predicts every filled square from its own font copy
// and pen model, and checks each response beat in order. A directed table
// runs first, then random phases under several register settings, with
// random idling on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module tb;
   import tgr_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 30;
   localparam int HOLD_CYCLES     = 300;
   localparam int IDLE_PCT        = 22;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 40;
   localparam int MAX_REPORTS     = 10;
   localparam int PITCH_COLS      = GLYPH_W + 1;
   localparam int LINE_ROWS       = GLYPH_H + 2;

   localparam logic [CODE_BITS-1:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      coord_type x;
      coord_type y;
      scale_type size;
      color_type color;
      logic      last;
   } rect_type;

   // one row of the directed table: either a register write or a character
   typedef struct packed {
      logic                 is_cfg;
      csr_idx_type          reg_idx;
      logic [31:0]          value;
      logic [CODE_BITS-1:0] code;
      logic                 new_text;
      logic                 typed;
      rect_type             first;
   } row_type;

   localparam rect_type NO_RECT = '0;

   // 5x7 font, bit 4 of a row is the leftmost dot
   localparam logic [GLYPH_W-1:0] DOT_ROWS [0:GLYPH_COUNT-1][0:GLYPH_H-1] = '{
      '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
      '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
      '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
      '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
      '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
      '{5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E},
      '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
      '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
      '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
      '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
      '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
      '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
      '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
      '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}
   };

   // Directed table. The first square is typed in only where it is obvious:
   // right after reset, and at the all-ones origin with the largest scale.
   localparam int DIRECTED_ROWS = 27;
   localparam row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      '{1'b0, CSR_ORIGIN_X, 32'h0, "A", 1'b1, 1'b1,
        '{16'h0001, 16'h0000, 4'h1, 32'hFFFF_FFFF, 1'b0}},
      '{1'b0, CSR_ORIGIN_X, 32'h0, "z",   1'b0, 1'b0, NO_RECT},
      '{1'b0, CSR_ORIGIN_X, 32'h0, "a",   1'b0, 1'b0, NO_RECT},
      '{1'b0, CSR_ORIGIN_X, 32'h0, "Z",   1'b0, 1'b0, NO_RECT},
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'h20, 1'b0, 1'b0, NO_RECT},  // space
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'h40, 1'b0, 1'b0, NO_RECT},  // just below A
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'h5B, 1'b0, 1'b0, NO_RECT},  // just above Z
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'h60, 1'b0, 1'b0, NO_RECT},  // just below a
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'h7B, 1'b0, 1'b0, NO_RECT},  // just above z
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'h80, 1'b0, 1'b0, NO_RECT},
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'hFF, 1'b0, 1'b0, NO_RECT},
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'h0A, 1'b0, 1'b0, NO_RECT},  // newline
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'h00, 1'b1, 1'b0, NO_RECT},  // end mark
      '{1'b0, CSR_ORIGIN_X, 32'h0, "W",   1'b0, 1'b0, NO_RECT},
      '{1'b1, CSR_ORIGIN_X,    32'h0000_FFFF, 8'h00, 1'b0, 1'b0, NO_RECT},
      '{1'b1, CSR_ORIGIN_Y,    32'h0000_FFFF, 8'h00, 1'b0, 1'b0, NO_RECT},
      '{1'b1, CSR_PIXEL_SCALE, 32'h0000_000F, 8'h00, 1'b0, 1'b0, NO_RECT},
      '{1'b1, CSR_INK_COLOR,   32'h0000_0000, 8'h00, 1'b0, 1'b0, NO_RECT},
      '{1'b0, CSR_ORIGIN_X, 32'h0, "H", 1'b1, 1'b1,
        '{16'hFFFF, 16'hFFFF, 4'hF, 32'h0000_0000, 1'b0}},
      '{1'b0, CSR_ORIGIN_X, 32'h0, "M",   1'b0, 1'b0, NO_RECT},
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'h0A, 1'b0, 1'b0, NO_RECT},  // newline wraps
      '{1'b0, CSR_ORIGIN_X, 32'h0, "q",   1'b0, 1'b0, NO_RECT},
      '{1'b1, CSR_PIXEL_SCALE, 32'h0000_0000, 8'h00, 1'b0, 1'b0, NO_RECT},
      '{1'b0, CSR_ORIGIN_X, 32'h0, "B",   1'b0, 1'b0, NO_RECT},  // zero scale
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'h0A, 1'b0, 1'b0, NO_RECT},
      '{1'b0, CSR_ORIGIN_X, 32'h0, 8'h20, 1'b1, 1'b0, NO_RECT},
      '{1'b0, CSR_ORIGIN_X, 32'h0, "G",   1'b0, 1'b0, NO_RECT}
   };

   // ports; every input starts at a known value
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CODE_BITS-1:0]     req_char_code = '0;
   logic                     req_new_text = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [COORD_BITS-1:0]    rsp_rect_x;
   logic [COORD_BITS-1:0]    rsp_rect_y;
   logic [SCALE_BITS-1:0]    rsp_rect_size;
   logic [COLOR_BITS-1:0]    rsp_rect_color;
   logic                     rsp_last_of_char;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // shadow registers and pen
   coord_type cfg_origin_x = '0;
   coord_type cfg_origin_y = '0;
   scale_type cfg_scale    = 4'd1;
   color_type cfg_color    = 32'hFFFF_FFFF;
   coord_type pen_x        = '0;
   coord_type pen_y        = '0;

   rect_type rects_due [$];
   int       fail_count    = 0;
   int       cycle_count   = 0;
   bit       no_idle       = 1'b0;
   int       hold_requests = 0;
   int       holds_taken   = 0;
   int       hold_left     = 0;

   text_glyph_rectangle_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_new_text     (req_new_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rect_x       (rsp_rect_x),
      .rsp_rect_y       (rsp_rect_y),
      .rsp_rect_size    (rsp_rect_size),
      .rsp_rect_color   (rsp_rect_color),
      .rsp_last_of_char (rsp_last_of_char),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Count cycles; drop the run if it never drains.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Count a failure; print only the first few.
   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%s", msg);
   endfunction

   // Advance the pen model for one character and queue the squares it draws.
   task automatic predict_rects(input logic [CODE_BITS-1:0] code, input logic nt);
      int letter;
      int total;
      int n;
      letter = -1;
      total  = 0;
      n      = 0;
      if (nt) begin
         pen_x = cfg_origin_x;
         pen_y = cfg_origin_y;
      end
      // end mark leaves the pen alone
      if (code == CHAR_NUL)
         return;
      if (code == CHAR_NEWLINE) begin
         pen_x = cfg_origin_x;
         pen_y = coord_type'(pen_y + LINE_ROWS * cfg_scale);
         return;
      end
      // fold lower case onto the same glyphs
      if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z)
         letter = int'(code - CHAR_LOWER_A);
      else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z)
         letter = int'(code - CHAR_UPPER_A);
      if (letter >= 0 && cfg_scale != 0) begin
         for (int r = 0; r < GLYPH_H; r++)
            total += $countones(DOT_ROWS[letter][r]);
         for (int r = 0; r < GLYPH_H; r++) begin
            for (int c = 0; c < GLYPH_W; c++) begin
               if (DOT_ROWS[letter][r][GLYPH_W-1-c]) begin
                  n++;
                  rects_due.push_back(rect_type'{
                     x:     coord_type'(pen_x + c * cfg_scale),
                     y:     coord_type'(pen_y + r * cfg_scale),
                     size:  cfg_scale,
                     color: cfg_color,
                     last:  (n == total)});
               end
            end
         end
      end
      // anything but the end mark and newline moves the pen one cell right
      pen_x = coord_type'(pen_x + PITCH_COLS * cfg_scale);
   endtask

   // Offer one character beat, hold it until taken, then maybe idle.
   task automatic send_char(input logic [CODE_BITS-1:0] code, input logic nt,
                            input logic typed, input rect_type first);
      int start;
      req_valid     <= 1'b1;
      req_char_code <= code;
      req_new_text  <= nt;
      do @(posedge clock); while (req_ready !== 1'b1);
      start = rects_due.size();
      predict_rects(code, nt);
      // a typed-in first square takes the place of the predicted one
      if (typed && rects_due.size() > start)
         rects_due[start] = first;
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every square, then let the back end settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rects_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register over the configuration port, then read it back.
   task automatic csr_write(input csr_idx_type idx, input logic [31:0] data);
      logic [31:0] kept;
      kept = '0;
      case (idx)
         CSR_ORIGIN_X: begin
            cfg_origin_x = data[COORD_BITS-1:0];
            kept = 32'(cfg_origin_x);
         end
         CSR_ORIGIN_Y: begin
            cfg_origin_y = data[COORD_BITS-1:0];
            kept = 32'(cfg_origin_y);
         end
         CSR_PIXEL_SCALE: begin
            cfg_scale = data[SCALE_BITS-1:0];
            kept = 32'(cfg_scale);
         end
         CSR_INK_COLOR: begin
            cfg_color = data;
            kept = data;
         end
         default: ;
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== kept)
         note_failure($sformatf("register %s read back %h, expected %h",
                                idx.name(), prdata, kept));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Pick a character: mostly letters, some spacing and control, some noise.
   function automatic logic [CODE_BITS-1:0] random_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30)
         return CHAR_UPPER_A + CODE_BITS'($urandom_range(25));
      else if (pick < 55)
         return CHAR_LOWER_A + CODE_BITS'($urandom_range(25));
      else if (pick < 65)
         return CHAR_SPACE;
      else if (pick < 72)
         return CHAR_NEWLINE;
      else if (pick < 76)
         return CHAR_NUL;
      return CODE_BITS'($urandom_range(255));
   endfunction

   // Response side: idle at random, run flat out in the steady phase, and
   // hold off for a long stretch whenever the stimulus asks for it.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_taken != hold_requests) begin
         rsp_ready   <= 1'b0;
         hold_left   <= HOLD_CYCLES;
         holds_taken <= holds_taken + 1;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Check each response beat against the oldest queued square.
   always @(posedge clock) begin : rsp_monitor
      rect_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (rects_due.size() == 0) begin
            note_failure($sformatf(
               "unexpected square x=%h y=%h size=%h color=%h last=%b",
               rsp_rect_x, rsp_rect_y, rsp_rect_size, rsp_rect_color,
               rsp_last_of_char));
         end else begin
            due = rects_due.pop_front();
            if (rsp_rect_x !== due.x || rsp_rect_y !== due.y ||
                rsp_rect_size !== due.size || rsp_rect_color !== due.color ||
                rsp_last_of_char !== due.last)
               note_failure($sformatf(
                  "square mismatch: expected x=%h y=%h size=%h color=%h last=%b, %s",
                  due.x, due.y, due.size, due.color, due.last,
                  $sformatf("got x=%h y=%h size=%h color=%h last=%b",
                            rsp_rect_x, rsp_rect_y, rsp_rect_size,
                            rsp_rect_color, rsp_last_of_char)));
         end
      end
   end

   // Main sequence: reset, directed table, random phases, drain, verdict.
   initial begin : stimulus
      logic [31:0] scale_word;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // walk the table; drain before any register write
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         if (DIRECTED[row].is_cfg) begin
            wait_idle();
            csr_write(DIRECTED[row].reg_idx, DIRECTED[row].value);
         end else begin
            send_char(DIRECTED[row].code, DIRECTED[row].new_text,
                      DIRECTED[row].typed, DIRECTED[row].first);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               csr_write(CSR_ORIGIN_X, 32'h0);
               csr_write(CSR_ORIGIN_Y, 32'h0);
               csr_write(CSR_PIXEL_SCALE, 32'h1);
               csr_write(CSR_INK_COLOR, $urandom());
            end
            1: begin
               csr_write(CSR_ORIGIN_X, 32'hFFFF_FFFF);
               csr_write(CSR_ORIGIN_Y, 32'hFFFF_FFFF);
               csr_write(CSR_PIXEL_SCALE, 32'hFFFF_FFFF);
               csr_write(CSR_INK_COLOR, 32'hFFFF_FFFF);
            end
            2: begin
               csr_write(CSR_ORIGIN_X, $urandom());
               csr_write(CSR_ORIGIN_Y, $urandom());
               csr_write(CSR_PIXEL_SCALE, 32'h0);
               csr_write(CSR_INK_COLOR, 32'h0);
            end
            default: begin
               // keep the upper word random to exercise register masking
               scale_word = $urandom();
               if ($urandom_range(7) == 0)
                  scale_word[SCALE_BITS-1:0] = '0;
               csr_write(CSR_ORIGIN_X, $urandom());
               csr_write(CSR_ORIGIN_Y, $urandom());
               csr_write(CSR_PIXEL_SCALE, scale_word);
               csr_write(CSR_INK_COLOR, $urandom());
            end
         endcase
         // hold the response side off while beats keep coming, so the
         // queue fills and the request side stalls
         if (phase == 0)
            hold_requests <= hold_requests + 1;
         // one phase with no idling on either side
         no_idle <= (phase == 1);
         for (int item = 0; item < ITEMS_PER_PHASE; item++)
            send_char(random_char(), ($urandom_range(99) < 8), 1'b0, NO_RECT);
      end

      wait_idle();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
hdl/tgr_pkg.sv
hdl/tgr_front.sv
hdl/tgr_queue.sv
hdl/tgr_back.sv
hdl/text_glyph_rectangle_generator.sv
sim/tb.sv
